FILE: hdl/pida_pkg.sv
// Package for the positional insert/delete array.
// Holds list depth, derived widths, action/status codes and sequencer states.
// No dependencies.
package pida_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 8;
    localparam int IDX_W  = 4;
    localparam int OCNT_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_TRAVERSE = 2'd0,
        ACT_INSERT   = 2'd1,
        ACT_DELETE   = 2'd2,
        ACT_UPDATE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_TRV_RD,
        S_TRV_OUT,
        S_RESP
    } t_state;

endpackage

FILE: hdl/pida_if.sv
// Valid/ready channel interfaces for the positional insert/delete array.
// Depends on pida_pkg for field widths.
interface pida_in_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         action;
    logic [pida_pkg::POS_W-1:0]         position;
    logic signed [pida_pkg::DATA_W-1:0] value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

interface pida_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic [pida_pkg::IDX_W-1:0]         index;
    logic signed [pida_pkg::DATA_W-1:0] element;
    logic                               last;
    logic [pida_pkg::OCNT_W-1:0]        count;

    modport source (output valid, output status, output index, output element,
                    output last, output count, input ready);
    modport sink   (input valid, input status, input index, input element,
                    input last, input count, output ready);
endinterface

FILE: hdl/pida_store.sv
// Entry storage: one write port, one read port with registered data.
// Depends on pida_pkg for depth and widths.
module pida_store (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [pida_pkg::ADDR_W-1:0]       i_waddr,
    input  logic signed [pida_pkg::DATA_W-1:0] i_wdata,
    input  logic [pida_pkg::ADDR_W-1:0]       i_raddr,
    output logic signed [pida_pkg::DATA_W-1:0] o_rdata
);
    import pida_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/positional_insert_delete_array.sv
// Top level of the positional insert/delete array.
// Depends on pida_pkg, pida_in_if/pida_out_if and pida_store.
//
//   channel  dir  transfer moves                      per request
//   i_req    in   action, position, value             one
//   o_rsp    out  status, index, element, last, count one, or one per entry
//
// A request is taken only when the sequencer is idle. Insert and delete
// move entries one at a time through the store, reading each entry and
// then writing it one place over; update and rejected actions go straight
// to the response, and a traverse reads and sends one entry at a time. Any
// wait on o_rsp.ready delays the point at which the next request is taken.
// Reset clears the count, the sequencer and the output valid flag only;
// entry contents stay undefined until written. A stalled response holds
// in the output register and the sequencer waits behind it.
module positional_insert_delete_array (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pida_in_if.sink   i_req,
    pida_out_if.source o_rsp
);
    import pida_pkg::*;

    // sequencer and list state
    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_used, n_used;
    logic [CNT_W-1:0]         r_ptr, n_ptr;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic signed [DATA_W-1:0] r_value, n_value;
    t_status                  r_status, n_status;

    // output register
    logic                     r_ov, n_ov;
    t_status                  r_ostatus, n_ostatus;
    logic [IDX_W-1:0]         r_oindex, n_oindex;
    logic signed [DATA_W-1:0] r_oelem, n_oelem;
    logic                     r_olast, n_olast;
    logic [OCNT_W-1:0]        r_ocount, n_ocount;

    // storage port
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;

    logic                     req_xfer;
    logic                     out_free;
    logic [POS_W-1:0]         used_w;
    logic [POS_W-1:0]         ptr_w;
    logic                     ptr_at_tail;

    assign req_xfer    = i_req.valid && i_req.ready;
    assign out_free    = !r_ov || o_rsp.ready;
    assign used_w      = POS_W'(r_used);
    assign ptr_w       = POS_W'(r_ptr);
    assign ptr_at_tail = (r_ptr + CNT_W'(1)) == r_used;

    pida_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    case (i_req.action)
                        ACT_TRAVERSE: n_state = (r_used == '0) ? S_RESP : S_TRV_RD;
                        ACT_INSERT: begin
                            if (r_used >= CNT_W'(DEPTH) || i_req.position > used_w) begin
                                n_state = S_RESP;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        ACT_DELETE: begin
                            if (r_used == '0 || i_req.position >= used_w) begin
                                n_state = S_RESP;
                            end else begin
                                n_state = S_DEL_RD;
                            end
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_INS_RD:  n_state = (ptr_w == r_pos) ? S_RESP : S_INS_WR;
            S_INS_WR:  n_state = S_INS_RD;
            S_DEL_RD:  n_state = ptr_at_tail ? S_RESP : S_DEL_WR;
            S_DEL_WR:  n_state = S_DEL_RD;
            S_TRV_RD:  n_state = S_TRV_OUT;
            S_TRV_OUT: begin
                if (out_free) begin
                    n_state = ptr_at_tail ? S_IDLE : S_TRV_RD;
                end
            end
            S_RESP:    n_state = out_free ? S_IDLE : S_RESP;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_used    = r_used;
        n_ptr     = r_ptr;
        n_pos     = r_pos;
        n_value   = r_value;
        n_status  = r_status;
        n_ov      = r_ov && !o_rsp.ready;
        n_ostatus = r_ostatus;
        n_oindex  = r_oindex;
        n_oelem   = r_oelem;
        n_olast   = r_olast;
        n_ocount  = r_ocount;
        mem_we    = 1'b0;
        mem_waddr = r_ptr[ADDR_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_ptr[ADDR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_pos    = i_req.position;
                    n_value  = i_req.value;
                    n_status = ST_OK;
                    case (i_req.action)
                        ACT_TRAVERSE: begin
                            n_pos = '0;
                            n_ptr = '0;
                            if (r_used == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        ACT_INSERT: begin
                            n_ptr = r_used;
                            if (r_used >= CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else if (i_req.position > used_w) begin
                                n_status = ST_BADPOS;
                            end
                        end
                        ACT_DELETE: begin
                            n_ptr = CNT_W'(i_req.position);
                            if (r_used == '0) begin
                                n_status = ST_EMPTY;
                            end else if (i_req.position >= used_w) begin
                                n_status = ST_BADPOS;
                            end
                        end
                        default: begin
                            // update in place on the transfer cycle
                            if (i_req.position >= used_w) begin
                                n_status = ST_BADPOS;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = i_req.position[ADDR_W-1:0];
                                mem_wdata = i_req.value;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (ptr_w == r_pos) begin
                    // gap is open: drop the new value in
                    mem_we    = 1'b1;
                    mem_waddr = r_ptr[ADDR_W-1:0];
                    mem_wdata = r_value;
                    n_used    = r_used + CNT_W'(1);
                end else begin
                    mem_raddr = ADDR_W'(r_ptr - CNT_W'(1));
                end
            end
            S_INS_WR: begin
                // move entry ptr-1 up to ptr
                mem_we = 1'b1;
                n_ptr  = r_ptr - CNT_W'(1);
            end
            S_DEL_RD: begin
                if (ptr_at_tail) begin
                    n_used = r_used - CNT_W'(1);
                end else begin
                    mem_raddr = ADDR_W'(r_ptr + CNT_W'(1));
                end
            end
            S_DEL_WR: begin
                // move entry ptr+1 down to ptr
                mem_we = 1'b1;
                n_ptr  = r_ptr + CNT_W'(1);
            end
            S_TRV_RD: begin
                mem_raddr = r_ptr[ADDR_W-1:0];
            end
            S_TRV_OUT: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_ostatus = ST_OK;
                    n_oindex  = IDX_W'(r_ptr);
                    n_oelem   = mem_rdata;
                    n_olast   = ptr_at_tail;
                    n_ocount  = OCNT_W'(r_used);
                    n_ptr     = r_ptr + CNT_W'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_ostatus = r_status;
                    n_oindex  = r_pos[IDX_W-1:0];
                    n_oelem   = '0;
                    n_olast   = 1'b1;
                    n_ocount  = OCNT_W'(r_used);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ov    <= n_ov;
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_pos     <= n_pos;
        r_value   <= n_value;
        r_status  <= n_status;
        r_ostatus <= n_ostatus;
        r_oindex  <= n_oindex;
        r_oelem   <= n_oelem;
        r_olast   <= n_olast;
        r_ocount  <= n_ocount;
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_ov;
    assign o_rsp.status  = r_ostatus;
    assign o_rsp.index   = r_oindex;
    assign o_rsp.element = r_oelem;
    assign o_rsp.last    = r_olast;
    assign o_rsp.count   = r_ocount;

endmodule
